// ----- hw/rtl/two_axis_pid_deadband_clamp_core_assert.svh -----
// ----------------------------------------------------------------------------
// two axis pid core assertion macros
// clocked assertion wrappers shared by the checker file
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_PID_DEADBAND_CLAMP_CORE_ASSERT_SVH
`define TWO_AXIS_PID_DEADBAND_CLAMP_CORE_ASSERT_SVH

// assertion that is switched off while reset is held
`define TDPC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tdpc assertion failed");

// assertion that also watches the reset cycles
`define TDPC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tdpc assertion failed");

`endif

// ----- hw/rtl/tdpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tdpc_pkg
// widths, register map, reset values and shared types of the two axis pid core
// ----------------------------------------------------------------------------
package tdpc_pkg;

  localparam int POS_W     = 12;
  localparam int ACC_W     = 32;
  localparam int GAIN_W    = 24;
  localparam int DB_W      = 11;
  localparam int LIM_W     = 15;
  localparam int OUT_W     = 16;
  localparam int E_W       = POS_W + 1;
  localparam int DV_W      = POS_W + 2;
  localparam int CMP_W     = (E_W > DB_W) ? E_W : DB_W;
  localparam int ACC_EXT_W = ((ACC_W > E_W) ? ACC_W : E_W) + 1;
  localparam int PP_W      = GAIN_W + 1 + E_W;
  localparam int DP_W      = GAIN_W + 1 + DV_W;
  localparam int IP_W      = GAIN_W + 1 + ACC_W;
  localparam int SUM_W     = IP_W + 2;
  localparam int FRAC_SHIFT = 8;
  localparam int ROUND_HALF = 128;
  localparam int Q_W       = SUM_W - FRAC_SHIFT;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DEAD_BAND = 3'd3,
    REG_OUT_LIMIT = 3'd4
  } reg_idx_t;

  localparam logic [GAIN_W-1:0] GAIN_P_RST    = GAIN_W'(39322);
  localparam logic [GAIN_W-1:0] GAIN_I_RST    = GAIN_W'(6554);
  localparam logic [GAIN_W-1:0] GAIN_D_RST    = GAIN_W'(184);
  localparam logic [DB_W-1:0]   DEAD_BAND_RST = DB_W'(10);
  localparam logic [LIM_W-1:0]  OUT_LIMIT_RST = LIM_W'(5120);

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [DB_W-1:0]   dead_band;
    logic [LIM_W-1:0]  out_limit;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic signed [OUT_W-1:0] drive;
  } lane_res_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] tilt_about_x;
    logic signed [OUT_W-1:0] tilt_about_y;
  } tilt_t;

endpackage

// ----- hw/rtl/tdpc_lane.sv -----
// ----------------------------------------------------------------------------
// tdpc_lane
// one axis of the pid: state update at accept outside the dead band, then multiply, sum, clamp
// ----------------------------------------------------------------------------
module tdpc_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_accept,
  input  logic signed [tdpc_pkg::POS_W-1:0]   pos,
  input  tdpc_pkg::cfg_t                      cfg,
  output tdpc_pkg::lane_res_t                 res
);

  logic signed [tdpc_pkg::E_W-1:0]       pos_ext;
  logic signed [tdpc_pkg::E_W-1:0]       err;
  logic        [tdpc_pkg::E_W-1:0]       mag;
  logic                                  dead;
  logic signed [tdpc_pkg::ACC_EXT_W-1:0] acc_sum;
  logic                                  acc_ovf;
  logic signed [tdpc_pkg::ACC_W-1:0]     acc_nxt;
  logic signed [tdpc_pkg::DV_W-1:0]      dv;

  logic signed [tdpc_pkg::ACC_W-1:0]     acc_r;
  logic signed [tdpc_pkg::E_W-1:0]       prev_r;

  logic                                  v1_r;
  logic                                  dead1_r;
  logic signed [tdpc_pkg::E_W-1:0]       e1_r;
  logic signed [tdpc_pkg::DV_W-1:0]      dv1_r;
  logic signed [tdpc_pkg::ACC_W-1:0]     acc1_r;

  logic signed [tdpc_pkg::GAIN_W:0]      gp_s;
  logic signed [tdpc_pkg::GAIN_W:0]      gi_s;
  logic signed [tdpc_pkg::GAIN_W:0]      gd_s;

  logic                                  v2_r;
  logic                                  dead2_r;
  logic signed [tdpc_pkg::PP_W-1:0]      pp2_r;
  logic signed [tdpc_pkg::DP_W-1:0]      dp2_r;
  logic signed [tdpc_pkg::IP_W-1:0]      ip2_r;

  logic signed [tdpc_pkg::SUM_W-1:0]     small_sum;
  logic                                  v3_r;
  logic                                  dead3_r;
  logic signed [tdpc_pkg::SUM_W-1:0]     sum3_r;

  logic signed [tdpc_pkg::Q_W-1:0]       q;
  logic signed [tdpc_pkg::Q_W-1:0]       lim;
  logic signed [tdpc_pkg::Q_W-1:0]       clamped;
  logic                                  v4_r;
  logic signed [tdpc_pkg::OUT_W-1:0]     drive4_r;

  // error, dead band, saturating integrator
  always_comb begin
    pos_ext = tdpc_pkg::E_W'(pos);
    err     = -pos_ext;
    mag     = pos_ext[tdpc_pkg::E_W-1] ? err : pos_ext;
    dead    = tdpc_pkg::CMP_W'(mag) <= tdpc_pkg::CMP_W'(cfg.dead_band);
    acc_sum = tdpc_pkg::ACC_EXT_W'(acc_r) + tdpc_pkg::ACC_EXT_W'(err);
    acc_ovf = !((&acc_sum[tdpc_pkg::ACC_EXT_W-1:tdpc_pkg::ACC_W-1]) ||
                (~|acc_sum[tdpc_pkg::ACC_EXT_W-1:tdpc_pkg::ACC_W-1]));
    if (acc_ovf) begin
      acc_nxt = {acc_sum[tdpc_pkg::ACC_EXT_W-1],
                 {(tdpc_pkg::ACC_W-1){~acc_sum[tdpc_pkg::ACC_EXT_W-1]}}};
    end else begin
      acc_nxt = acc_sum[tdpc_pkg::ACC_W-1:0];
    end
    dv = tdpc_pkg::DV_W'(err) - tdpc_pkg::DV_W'(prev_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      prev_r <= '0;
      v1_r   <= 1'b0;
    end else begin
      v1_r <= in_accept;
      if (in_accept && !dead) begin
        acc_r  <= acc_nxt;
        prev_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    dead1_r <= dead;
    e1_r    <= err;
    dv1_r   <= dv;
    acc1_r  <= acc_nxt;
  end

  // products
  assign gp_s = $signed({1'b0, cfg.gain_p});
  assign gi_s = $signed({1'b0, cfg.gain_i});
  assign gd_s = $signed({1'b0, cfg.gain_d});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dead2_r <= dead1_r;
    pp2_r   <= tdpc_pkg::PP_W'(gp_s) * tdpc_pkg::PP_W'(e1_r);
    dp2_r   <= tdpc_pkg::DP_W'(gd_s) * tdpc_pkg::DP_W'(dv1_r);
    ip2_r   <= tdpc_pkg::IP_W'(gi_s) * tdpc_pkg::IP_W'(acc1_r);
  end

  // sum with rounding offset
  assign small_sum = tdpc_pkg::SUM_W'(pp2_r) + tdpc_pkg::SUM_W'(dp2_r) +
                     tdpc_pkg::SUM_W'(tdpc_pkg::ROUND_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dead3_r <= dead2_r;
    sum3_r  <= tdpc_pkg::SUM_W'(ip2_r) + small_sum;
  end

  // floor to q8 and clamp
  always_comb begin
    q   = $signed(sum3_r[tdpc_pkg::SUM_W-1:tdpc_pkg::FRAC_SHIFT]);
    lim = $signed(tdpc_pkg::Q_W'(cfg.out_limit));
    if (dead3_r) begin
      clamped = '0;
    end else if (q > lim) begin
      clamped = lim;
    end else if (q < -lim) begin
      clamped = -lim;
    end else begin
      clamped = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    drive4_r <= clamped[tdpc_pkg::OUT_W-1:0];
  end

  assign res.valid = v4_r;
  assign res.drive = drive4_r;

endmodule

// ----- hw/rtl/tdpc_merge.sv -----
// ----------------------------------------------------------------------------
// tdpc_merge
// maps lane drives onto tilts and queues result beats, tracks credits
// ----------------------------------------------------------------------------
module tdpc_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_accept,
  input  tdpc_pkg::lane_res_t                res_x,
  input  tdpc_pkg::lane_res_t                res_y,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [tdpc_pkg::OUT_W-1:0]  out_tilt_about_x,
  output logic signed [tdpc_pkg::OUT_W-1:0]  out_tilt_about_y,
  output logic                               full
);

  tdpc_pkg::tilt_t                   fifo_r [tdpc_pkg::FIFO_DEPTH];
  tdpc_pkg::tilt_t                   wr_beat;
  tdpc_pkg::tilt_t                   rd_beat;
  logic [tdpc_pkg::PTR_W-1:0]        wr_ptr_r;
  logic [tdpc_pkg::PTR_W-1:0]        rd_ptr_r;
  logic [tdpc_pkg::CNT_W-1:0]        count_r;
  logic [tdpc_pkg::CNT_W-1:0]        credit_r;
  logic                              wr_en;
  logic                              rd_en;

  assign wr_en = res_x.valid & res_y.valid;
  assign rd_en = out_valid & ~out_stall;

  assign wr_beat.tilt_about_x = res_y.drive;
  assign wr_beat.tilt_about_y = -res_x.drive;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_r[wr_ptr_r] <= wr_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      credit_r <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r  <= count_r + tdpc_pkg::CNT_W'(wr_en) - tdpc_pkg::CNT_W'(rd_en);
      credit_r <= credit_r + tdpc_pkg::CNT_W'(in_accept) - tdpc_pkg::CNT_W'(rd_en);
    end
  end

  assign rd_beat          = fifo_r[rd_ptr_r];
  assign out_valid        = count_r != '0;
  assign out_tilt_about_x = rd_beat.tilt_about_x;
  assign out_tilt_about_y = rd_beat.tilt_about_y;
  assign full             = credit_r == tdpc_pkg::CNT_W'(tdpc_pkg::FIFO_DEPTH);

endmodule

// ----- hw/rtl/two_axis_pid_deadband_clamp_core.sv -----
// ----------------------------------------------------------------------------
// two_axis_pid_deadband_clamp_core
// two axis pid with dead band and output clamp for ball balancing tilt
// ----------------------------------------------------------------------------
// Takes one x,y position beat per cycle while in_stall is low and returns
// one tilt beat per input beat. Each axis has its own lane; outside the
// dead band the integrator and previous error update in the cycle the beat
// is accepted, then the lane runs multiply, sum and clamp stages ahead of
// the result queue. Throughput is one beat per clock unless stalled,
// bounded by an eight-entry result queue whose credit count raises in_stall
// once eight beats are outstanding. Gains, dead band and limit are to be
// written over the APB port only while idle; the block does not enforce it.
module two_axis_pid_deadband_clamp_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tdpc_pkg::ADDR_W-1:0]         paddr,
  input  logic [tdpc_pkg::DATA_W-1:0]         pwdata,
  output logic [tdpc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tdpc_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [tdpc_pkg::POS_W-1:0]   in_pos_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tdpc_pkg::OUT_W-1:0]   out_tilt_about_x,
  output logic signed [tdpc_pkg::OUT_W-1:0]   out_tilt_about_y
);

  tdpc_pkg::cfg_t            cfg_r;
  tdpc_pkg::reg_idx_t        reg_idx;
  tdpc_pkg::lane_res_t       res_x;
  tdpc_pkg::lane_res_t       res_y;
  logic                      cfg_wr;
  logic                      in_accept;
  logic                      full;

  assign pready    = 1'b1;
  assign reg_idx   = tdpc_pkg::reg_idx_t'(paddr[tdpc_pkg::ADDR_W-1:2]);
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign in_accept = in_valid & ~in_stall;
  assign in_stall  = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p    <= tdpc_pkg::GAIN_P_RST;
      cfg_r.gain_i    <= tdpc_pkg::GAIN_I_RST;
      cfg_r.gain_d    <= tdpc_pkg::GAIN_D_RST;
      cfg_r.dead_band <= tdpc_pkg::DEAD_BAND_RST;
      cfg_r.out_limit <= tdpc_pkg::OUT_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        tdpc_pkg::REG_GAIN_P: begin
          cfg_r.gain_p <= pwdata[tdpc_pkg::GAIN_W-1:0];
        end
        tdpc_pkg::REG_GAIN_I: begin
          cfg_r.gain_i <= pwdata[tdpc_pkg::GAIN_W-1:0];
        end
        tdpc_pkg::REG_GAIN_D: begin
          cfg_r.gain_d <= pwdata[tdpc_pkg::GAIN_W-1:0];
        end
        tdpc_pkg::REG_DEAD_BAND: begin
          cfg_r.dead_band <= pwdata[tdpc_pkg::DB_W-1:0];
        end
        tdpc_pkg::REG_OUT_LIMIT: begin
          cfg_r.out_limit <= pwdata[tdpc_pkg::LIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tdpc_pkg::REG_GAIN_P:    prdata = tdpc_pkg::DATA_W'(cfg_r.gain_p);
      tdpc_pkg::REG_GAIN_I:    prdata = tdpc_pkg::DATA_W'(cfg_r.gain_i);
      tdpc_pkg::REG_GAIN_D:    prdata = tdpc_pkg::DATA_W'(cfg_r.gain_d);
      tdpc_pkg::REG_DEAD_BAND: prdata = tdpc_pkg::DATA_W'(cfg_r.dead_band);
      tdpc_pkg::REG_OUT_LIMIT: prdata = tdpc_pkg::DATA_W'(cfg_r.out_limit);
      default:                 prdata = '0;
    endcase
  end

  tdpc_lane u_lane_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .pos       (in_pos_x),
    .cfg       (cfg_r),
    .res       (res_x)
  );

  tdpc_lane u_lane_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .pos       (in_pos_y),
    .cfg       (cfg_r),
    .res       (res_y)
  );

  tdpc_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_accept        (in_accept),
    .res_x            (res_x),
    .res_y            (res_y),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_tilt_about_x (out_tilt_about_x),
    .out_tilt_about_y (out_tilt_about_y),
    .full             (full)
  );

endmodule

// ----- hw/rtl/tdpc_checker.sv -----
// ----------------------------------------------------------------------------
// tdpc_checker
// port level checks of the two axis pid core, bound to the top level
// ----------------------------------------------------------------------------
`include "two_axis_pid_deadband_clamp_core_assert.svh"

module tdpc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [tdpc_pkg::OUT_W-1:0]   out_tilt_about_x,
  input logic signed [tdpc_pkg::OUT_W-1:0]   out_tilt_about_y
);

  // result queue held while stalled
  `TDPC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_tilt_about_x) && $stable(out_tilt_about_y))

  // reset empties the pipe and frees all credits
  `TDPC_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid && !in_stall)

  // a result only shows up behind an accepted beat
  `TDPC_ASSERT(a_out_latency, clk, rst_n, $rose(out_valid) |-> $past(in_valid && !in_stall, 5))

  // clamped drives are symmetric, never the most negative code
  `TDPC_ASSERT(a_out_range, clk, rst_n, out_valid |-> out_tilt_about_x != 16'sh8000 && out_tilt_about_y != 16'sh8000)

endmodule

bind two_axis_pid_deadband_clamp_core tdpc_checker u_tdpc_checker (.*);

// ----- verif/two_axis_pid_deadband_clamp_core_test.sv -----
// ----------------------------------------------------------------------------
// two_axis_pid_deadband_clamp_core_test
// self-checking bench for the two axis pid core with dead band and clamp
// ----------------------------------------------------------------------------
// Position beats go in through the valid/stall input channel and every tilt
// beat is checked against a cycle-free predictor of both pid lanes kept in
// the bench. Directed tests cover dead band edges, position extremes, zero
// and full gains, zero and full limit, rounding of halves and a write to an
// unmapped register. Random tests then run ball trajectories, held offsets,
// dead band edges and noise under many register settings, with the sender
// and receiver idling at random in two of three phases. Registers are written over
// the apb port only when no tilt beat is outstanding.
module two_axis_pid_deadband_clamp_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_NONE     = 3'd5;
  localparam int         SETTLE_CYCLES = 12;
  localparam longint     ACC_MAX  = (longint'(1) <<< (tdpc_pkg::ACC_W - 1)) - 1;
  localparam longint     ACC_MIN  = -ACC_MAX - 1;
  localparam longint     PROD_SAT = longint'(1) <<< 60;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [tdpc_pkg::ADDR_W-1:0]       paddr = '0;
  logic [tdpc_pkg::DATA_W-1:0]       pwdata = '0;
  logic [tdpc_pkg::DATA_W-1:0]       prdata;
  logic                              pready;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [tdpc_pkg::POS_W-1:0] in_pos_x = '0;
  logic signed [tdpc_pkg::POS_W-1:0] in_pos_y = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [tdpc_pkg::OUT_W-1:0] out_tilt_about_x;
  logic signed [tdpc_pkg::OUT_W-1:0] out_tilt_about_y;

  tdpc_pkg::cfg_t                    pid_cfg;
  logic signed [tdpc_pkg::ACC_W-1:0] integ_sum [2];
  logic signed [tdpc_pkg::E_W-1:0]   last_err [2];
  tdpc_pkg::tilt_t                   expected_tilts [$];
  int                                mismatches = 0;
  int                                feed_idle_pct = 0;
  int                                drain_stall_pct = 0;

  two_axis_pid_deadband_clamp_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tilt_about_x(out_tilt_about_x),
    .out_tilt_about_y(out_tilt_about_y)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

  // lane 0 is x, lane 1 is y
  function automatic logic signed [tdpc_pkg::OUT_W-1:0] axis_drive(
    input int lane,
    input logic signed [tdpc_pkg::POS_W-1:0] pos);
    longint p, e, acc, mag, iterm, total, q, lim;
    p = pos;
    mag = (p < 0) ? -p : p;
    if (mag <= longint'(pid_cfg.dead_band)) return '0;
    e = -p;
    acc = longint'(integ_sum[lane]) + e;
    if (acc > ACC_MAX) acc = ACC_MAX;
    else if (acc < ACC_MIN) acc = ACC_MIN;
    integ_sum[lane] = acc[tdpc_pkg::ACC_W-1:0];
    mag = (acc < 0) ? -acc : acc;
    if (pid_cfg.gain_i == '0 || mag == 0) iterm = 0;
    else if (mag > PROD_SAT / longint'(pid_cfg.gain_i)) iterm = PROD_SAT;
    else iterm = mag * longint'(pid_cfg.gain_i);
    if (acc < 0) iterm = -iterm;
    total = longint'(pid_cfg.gain_p) * e + iterm
          + longint'(pid_cfg.gain_d) * (e - longint'(last_err[lane]));
    last_err[lane] = e[tdpc_pkg::E_W-1:0];
    q = (total + tdpc_pkg::ROUND_HALF) >>> tdpc_pkg::FRAC_SHIFT;
    lim = longint'(pid_cfg.out_limit);
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q[tdpc_pkg::OUT_W-1:0];
  endfunction

  function automatic tdpc_pkg::tilt_t predict_tilt(
    input logic signed [tdpc_pkg::POS_W-1:0] x,
    input logic signed [tdpc_pkg::POS_W-1:0] y);
    tdpc_pkg::tilt_t t;
    logic signed [tdpc_pkg::OUT_W-1:0] drive_x;
    drive_x = axis_drive(0, x);
    t.tilt_about_x = axis_drive(1, y);
    t.tilt_about_y = -drive_x;
    return t;
  endfunction

  function automatic int fold_pos(input int p);
    if (p > 2047) return 2047;
    if (p < -2048) return -2048;
    return p;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    if (mismatches < 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    tdpc_pkg::tilt_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tilts.size() == 0) begin
        note_mismatch("unexpected tilt beat", 0, 0);
      end else begin
        want = expected_tilts.pop_front();
        if (out_tilt_about_x !== want.tilt_about_x)
          note_mismatch("tilt_about_x", want.tilt_about_x, out_tilt_about_x);
        if (out_tilt_about_y !== want.tilt_about_y)
          note_mismatch("tilt_about_y", want.tilt_about_y, out_tilt_about_y);
      end
    end
    out_stall <= ($urandom_range(99) < drain_stall_pct);
  end

  task automatic send_position(input logic signed [tdpc_pkg::POS_W-1:0] x,
                               input logic signed [tdpc_pkg::POS_W-1:0] y);
    while ($urandom_range(99) < feed_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_tilts.push_back(predict_tilt(x, y));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_tilts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] index,
                           input logic [tdpc_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tdpc_pkg::ADDR_W'({index, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (index)
      tdpc_pkg::REG_GAIN_P:    pid_cfg.gain_p = value[tdpc_pkg::GAIN_W-1:0];
      tdpc_pkg::REG_GAIN_I:    pid_cfg.gain_i = value[tdpc_pkg::GAIN_W-1:0];
      tdpc_pkg::REG_GAIN_D:    pid_cfg.gain_d = value[tdpc_pkg::GAIN_W-1:0];
      tdpc_pkg::REG_DEAD_BAND: pid_cfg.dead_band = value[tdpc_pkg::DB_W-1:0];
      tdpc_pkg::REG_OUT_LIMIT: pid_cfg.out_limit = value[tdpc_pkg::LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_setting(input logic [tdpc_pkg::GAIN_W-1:0] gp,
                                 input logic [tdpc_pkg::GAIN_W-1:0] gi,
                                 input logic [tdpc_pkg::GAIN_W-1:0] gd,
                                 input logic [tdpc_pkg::DB_W-1:0]   db,
                                 input logic [tdpc_pkg::LIM_W-1:0]  lim);
    apb_write(tdpc_pkg::REG_GAIN_P, tdpc_pkg::DATA_W'(gp));
    apb_write(tdpc_pkg::REG_GAIN_I, tdpc_pkg::DATA_W'(gi));
    apb_write(tdpc_pkg::REG_GAIN_D, tdpc_pkg::DATA_W'(gd));
    apb_write(tdpc_pkg::REG_DEAD_BAND, tdpc_pkg::DATA_W'(db));
    apb_write(tdpc_pkg::REG_OUT_LIMIT, tdpc_pkg::DATA_W'(lim));
  endtask

  task automatic test_reset_settings();
    send_position(0, 0);
    send_position(10, -10);
    send_position(11, -11);
    send_position(-11, 11);
    send_position(2047, -2048);
    send_position(-2048, 2047);
    send_position(2047, 2047);
    send_position(-2048, -2048);
  endtask

  task automatic test_gain_limit_extremes();
    drain_results();
    program_setting('0, '0, '0, tdpc_pkg::DEAD_BAND_RST, tdpc_pkg::OUT_LIMIT_RST);
    send_position(500, -500);
    drain_results();
    program_setting('1, '1, '1, '0, '1);
    send_position(1, -1);
    send_position(-2048, 2047);
    send_position(0, 0);
    drain_results();
    apb_write(tdpc_pkg::REG_OUT_LIMIT, '0);
    send_position(1000, -1000);
    drain_results();
    apb_write(tdpc_pkg::REG_OUT_LIMIT, tdpc_pkg::DATA_W'({tdpc_pkg::LIM_W{1'b1}}));
    apb_write(tdpc_pkg::REG_DEAD_BAND, tdpc_pkg::DATA_W'({tdpc_pkg::DB_W{1'b1}}));
    send_position(2047, -2047);
    send_position(-2048, 2047);
  endtask

  // gain of half an lsb shows which way exact halves round
  task automatic test_rounding_and_unmapped_write();
    drain_results();
    program_setting(tdpc_pkg::GAIN_W'(128), '0, '0, '0, '1);
    send_position(-1, 1);
    send_position(1, -1);
    send_position(-3, 3);
    drain_results();
    apb_write(REG_NONE, '1);
    send_position(-2, 2);
  endtask

  task automatic program_random_setting();
    logic [tdpc_pkg::GAIN_W-1:0] gp, gi, gd;
    logic [tdpc_pkg::DB_W-1:0]   db;
    logic [tdpc_pkg::LIM_W-1:0]  lim;
    case ($urandom_range(4))
      0: begin
        gp = tdpc_pkg::GAIN_P_RST; gi = tdpc_pkg::GAIN_I_RST; gd = tdpc_pkg::GAIN_D_RST;
        db = tdpc_pkg::DEAD_BAND_RST; lim = tdpc_pkg::OUT_LIMIT_RST;
      end
      1: begin
        gp = tdpc_pkg::GAIN_W'($urandom_range(1 << 18));
        gi = tdpc_pkg::GAIN_W'($urandom_range(1 << 14));
        gd = tdpc_pkg::GAIN_W'($urandom_range(1 << 16));
        db = tdpc_pkg::DB_W'($urandom_range(50));
        lim = tdpc_pkg::LIM_W'($urandom_range(32767));
      end
      2: begin
        gp = tdpc_pkg::GAIN_W'($urandom);
        gi = tdpc_pkg::GAIN_W'($urandom);
        gd = tdpc_pkg::GAIN_W'($urandom);
        db = tdpc_pkg::DB_W'($urandom);
        lim = tdpc_pkg::LIM_W'($urandom);
      end
      3: begin
        gp = '1; gi = '1; gd = '1; db = '0; lim = '1;
      end
      default: begin
        gp = tdpc_pkg::GAIN_W'($urandom);
        gi = tdpc_pkg::GAIN_W'($urandom_range(255));
        gd = tdpc_pkg::GAIN_W'($urandom);
        db = tdpc_pkg::DB_W'($urandom_range(2047));
        lim = tdpc_pkg::LIM_W'($urandom_range(255));
      end
    endcase
    program_setting(gp, gi, gd, db, lim);
  endtask

  task automatic test_random_tracking(input int n_blocks);
    int sent, mode, run_len, px, py, vx, vy;
    for (int blk = 0; blk < n_blocks; blk++) begin
      drain_results();
      program_random_setting();
      sent = 0;
      px = $urandom_range(4095) - 2048;
      py = $urandom_range(4095) - 2048;
      while (sent < 100) begin
        mode = $urandom_range(9);
        run_len = $urandom_range(30, 4);
        vx = $urandom_range(80) - 40;
        vy = $urandom_range(80) - 40;
        for (int k = 0; k < run_len && sent < 100; k++) begin
          case (mode)
            0, 1, 2, 3: begin
              px = px + vx + $urandom_range(6) - 3;
              py = py + vy + $urandom_range(6) - 3;
              if (px > 2047 || px < -2048) vx = -vx;
              if (py > 2047 || py < -2048) vy = -vy;
              px = fold_pos(px);
              py = fold_pos(py);
            end
            4, 5: ;
            6: begin
              px = fold_pos(int'(pid_cfg.dead_band) + $urandom_range(2) - 1);
              py = fold_pos(int'(pid_cfg.dead_band) + $urandom_range(2) - 1);
              if ($urandom_range(1)) px = -px;
              if ($urandom_range(1)) py = -py;
            end
            7: begin
              px = $urandom_range(1) ? 2047 : -2048;
              py = $urandom_range(1) ? 2047 : -2048;
            end
            default: begin
              px = $urandom_range(4095) - 2048;
              py = $urandom_range(4095) - 2048;
            end
          endcase
          send_position(tdpc_pkg::POS_W'(px), tdpc_pkg::POS_W'(py));
          sent++;
        end
      end
    end
  endtask

  initial begin
    pid_cfg = '{tdpc_pkg::GAIN_P_RST, tdpc_pkg::GAIN_I_RST, tdpc_pkg::GAIN_D_RST,
                tdpc_pkg::DEAD_BAND_RST, tdpc_pkg::OUT_LIMIT_RST};
    integ_sum[0] = '0;
    integ_sum[1] = '0;
    last_err[0] = '0;
    last_err[1] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    feed_idle_pct = 31;
    drain_stall_pct = 86;
    test_reset_settings();
    test_gain_limit_extremes();
    test_rounding_and_unmapped_write();
    test_random_tracking(7);

    feed_idle_pct = 86;
    drain_stall_pct = 31;
    test_random_tracking(7);

    feed_idle_pct = 0;
    drain_stall_pct = 0;
    test_random_tracking(7);

    drain_results();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
